[rtl/settings_command_parser_defines.svh]
// Assertion helpers for the settings command parser.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef SETTINGS_COMMAND_PARSER_DEFINES_SVH
`define SETTINGS_COMMAND_PARSER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SCP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define SCP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/scp_pkg.sv]
`timescale 1ns / 1ps

package scp_pkg;

  localparam int FIELD_LIMIT_DEF = 63;

  // Parser phases.
  localparam logic [1:0] PH_BLANK = 2'd0;
  localparam logic [1:0] PH_NAME  = 2'd1;
  localparam logic [1:0] PH_VALUE = 2'd2;

  // Number reader phases.
  localparam logic [1:0] NP_START  = 2'd0;
  localparam logic [1:0] NP_SIGN   = 2'd1;
  localparam logic [1:0] NP_DIGITS = 2'd2;
  localparam logic [1:0] NP_DONE   = 2'd3;

  // Command codes.
  localparam logic [2:0] CMD_OTHER  = 3'd0;
  localparam logic [2:0] CMD_ICTRL  = 3'd1;
  localparam logic [2:0] CMD_RED    = 3'd2;
  localparam logic [2:0] CMD_GREEN  = 3'd3;
  localparam logic [2:0] CMD_BLUE   = 3'd4;
  localparam logic [2:0] CMD_FAN    = 3'd5;
  localparam logic [2:0] CMD_CHG_EN = 3'd6;
  localparam logic [2:0] CMD_SAVE   = 3'd7;

  localparam int         NAME_COUNT = 7;
  localparam logic [6:0] ALL_NAMES  = 7'h7F;

  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_SEMI  = 8'h3B;

  localparam logic [9:0] MAG_MAX   = 10'd1023;
  localparam logic [6:0] PCT_MAX   = 7'd100;
  localparam logic [6:0] FAN_RESET = 7'd49;

  // Value reader state that travels between the parser and its helpers.
  typedef struct packed {
    logic [1:0] nphase;
    logic       neg;
    logic [9:0] mag;
  } num_t;

  // One result item.
  typedef struct packed {
    logic [2:0]         command;
    logic signed [10:0] parsed_value;
    logic               accepted;
    logic               save_request;
    logic [6:0]         current_level;
    logic [6:0]         red_level;
    logic [6:0]         green_level_out;
    logic [6:0]         blue_level_out;
    logic [6:0]         fan_percent;
    logic               charge_enable;
    logic [6:0]         fan_compare;
  } res_t;

  // Length of each known name, indexed like the candidate bits.
  function automatic logic [2:0] name_size(input logic [2:0] idx);
    logic [2:0] len;
    case (idx)
      3'd0:    len = 3'd5; // ICTRL
      3'd1:    len = 3'd1; // R
      3'd2:    len = 3'd1; // G
      3'd3:    len = 3'd1; // B
      3'd4:    len = 3'd3; // FAN
      3'd5:    len = 3'd6; // CHG_EN
      3'd6:    len = 3'd4; // SAVE
      default: len = 3'd0;
    endcase
    return len;
  endfunction

  // Character of a known name at a position; zero past its end.
  function automatic logic [7:0] name_char(input logic [2:0] idx, input logic [2:0] pos);
    logic [47:0] txt;
    logic [7:0]  ch;
    case (idx)
      3'd0:    txt = {8'h00, "LRTCI"};
      3'd1:    txt = {40'h0, "R"};
      3'd2:    txt = {40'h0, "G"};
      3'd3:    txt = {40'h0, "B"};
      3'd4:    txt = {24'h0, "NAF"};
      3'd5:    txt = "NE_GHC";
      3'd6:    txt = {16'h0, "EVAS"};
      default: txt = 48'h0;
    endcase
    case (pos)
      3'd0:    ch = txt[7:0];
      3'd1:    ch = txt[15:8];
      3'd2:    ch = txt[23:16];
      3'd3:    ch = txt[31:24];
      3'd4:    ch = txt[39:32];
      3'd5:    ch = txt[47:40];
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

[rtl/scp_name_match.sv]
`timescale 1ns / 1ps

module scp_name_match #(
  parameter int FIELD_LIMIT = scp_pkg::FIELD_LIMIT_DEF,
  parameter int POS_W       = $clog2(FIELD_LIMIT + 1)
) (
  input  logic [7:0]       data_byte,
  input  logic [6:0]       cand_in,
  input  logic [POS_W-1:0] pos_in,
  output logic [6:0]       feed_cand,
  output logic [POS_W-1:0] feed_pos,
  output logic [6:0]       end_cand
);

  // Each candidate name survives only while every character so far matches.
  always_comb begin
    feed_cand = 7'd0;
    feed_pos  = pos_in;
    end_cand  = 7'd0;
    if (pos_in < POS_W'(FIELD_LIMIT)) begin
      feed_pos = pos_in + POS_W'(1);
      for (int i = 0; i < scp_pkg::NAME_COUNT; i++) begin
        feed_cand[i] = cand_in[i] &&
                       (pos_in < POS_W'(scp_pkg::name_size(3'(i)))) &&
                       (scp_pkg::name_char(3'(i), pos_in[2:0]) == data_byte);
      end
    end
    for (int i = 0; i < scp_pkg::NAME_COUNT; i++) begin
      end_cand[i] = cand_in[i] && (pos_in == POS_W'(scp_pkg::name_size(3'(i))));
    end
  end

endmodule

[rtl/scp_value_reader.sv]
`timescale 1ns / 1ps

module scp_value_reader #(
  parameter int FIELD_LIMIT = scp_pkg::FIELD_LIMIT_DEF,
  parameter int POS_W       = $clog2(FIELD_LIMIT + 1)
) (
  input  logic [7:0]       data_byte,
  input  scp_pkg::num_t    num_in,
  input  logic [POS_W-1:0] dpos_in,
  output scp_pkg::num_t    num_out,
  output logic [POS_W-1:0] dpos_out
);

  logic        is_digit;
  logic        is_space;
  logic [13:0] mag_wide;
  logic [9:0]  mag_sat;

  assign is_digit = (data_byte >= scp_pkg::CHAR_ZERO) && (data_byte <= scp_pkg::CHAR_NINE);
  assign is_space = (data_byte == scp_pkg::CHAR_SPACE) ||
                    ((data_byte >= scp_pkg::CHAR_TAB) && (data_byte <= scp_pkg::CHAR_CR));
  assign mag_wide = 14'(num_in.mag) * 14'd10 + 14'(data_byte[3:0]);
  assign mag_sat  = (mag_wide > 14'(scp_pkg::MAG_MAX)) ? scp_pkg::MAG_MAX : mag_wide[9:0];

  always_comb begin
    num_out  = num_in;
    dpos_out = dpos_in;
    if (dpos_in < POS_W'(FIELD_LIMIT)) begin
      dpos_out = dpos_in + POS_W'(1);
      case (num_in.nphase)
        scp_pkg::NP_START: begin
          if (is_space) begin
            num_out = num_in;
          end else if (data_byte == scp_pkg::CHAR_PLUS || data_byte == scp_pkg::CHAR_MINUS) begin
            num_out.neg    = (data_byte == scp_pkg::CHAR_MINUS);
            num_out.nphase = scp_pkg::NP_SIGN;
          end else if (is_digit) begin
            num_out.mag    = mag_sat;
            num_out.nphase = scp_pkg::NP_DIGITS;
          end else begin
            num_out.nphase = scp_pkg::NP_DONE;
          end
        end
        scp_pkg::NP_SIGN, scp_pkg::NP_DIGITS: begin
          if (is_digit) begin
            num_out.mag    = mag_sat;
            num_out.nphase = scp_pkg::NP_DIGITS;
          end else begin
            num_out.nphase = scp_pkg::NP_DONE;
          end
        end
        default: begin
          num_out = num_in;
        end
      endcase
    end
  end

endmodule

[rtl/scp_store.sv]
`timescale 1ns / 1ps

module scp_store (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            fire,
  input  logic [6:0]      cand,
  input  scp_pkg::num_t   num,
  output scp_pkg::res_t   res
);

  logic [6:0] ictrl_r, ictrl_nxt;
  logic [6:0] red_r, red_nxt;
  logic [6:0] green_r, green_nxt;
  logic [6:0] blue_r, blue_nxt;
  logic [6:0] fan_r, fan_nxt;
  logic       chg_r, chg_nxt;
  logic [2:0] code;
  logic       pct;
  logic       is_zero;
  logic       is_one;

  // The first surviving candidate gives the command.
  always_comb begin
    code = scp_pkg::CMD_OTHER;
    for (int i = scp_pkg::NAME_COUNT - 1; i >= 0; i--) begin
      if (cand[i]) begin
        code = 3'(i + 1);
      end
    end
  end

  assign is_zero = (num.mag == 10'd0);
  assign is_one  = !num.neg && (num.mag == 10'd1);
  assign pct     = (num.mag <= 10'(scp_pkg::PCT_MAX)) && (!num.neg || is_zero);

  always_comb begin
    ictrl_nxt = ictrl_r;
    red_nxt   = red_r;
    green_nxt = green_r;
    blue_nxt  = blue_r;
    fan_nxt   = fan_r;
    chg_nxt   = chg_r;
    res.accepted     = 1'b0;
    res.save_request = 1'b0;
    case (code)
      scp_pkg::CMD_ICTRL: begin
        if (pct) ictrl_nxt = num.mag[6:0];
        res.accepted = 1'b1;
      end
      scp_pkg::CMD_RED: begin
        if (pct) red_nxt = num.mag[6:0];
        res.accepted = 1'b1;
      end
      scp_pkg::CMD_GREEN: begin
        if (pct) green_nxt = num.mag[6:0];
        res.accepted = 1'b1;
      end
      scp_pkg::CMD_BLUE: begin
        if (pct) blue_nxt = num.mag[6:0];
        res.accepted = 1'b1;
      end
      scp_pkg::CMD_FAN: begin
        if (pct) fan_nxt = num.mag[6:0];
        res.accepted = 1'b1;
      end
      scp_pkg::CMD_CHG_EN: begin
        if (is_zero || is_one) chg_nxt = is_one;
        res.accepted = 1'b1;
      end
      scp_pkg::CMD_SAVE: begin
        res.accepted     = is_one;
        res.save_request = is_one;
      end
      default: begin
        res.accepted = 1'b0;
      end
    endcase
    res.command         = code;
    res.parsed_value    = num.neg ? -$signed({1'b0, num.mag}) : $signed({1'b0, num.mag});
    res.current_level   = ictrl_nxt;
    res.red_level       = red_nxt;
    res.green_level_out = green_nxt;
    res.blue_level_out  = blue_nxt;
    res.fan_percent     = fan_nxt;
    res.charge_enable   = chg_nxt;
    // For a fan level of 0 to 100, level*99/100 is the level minus one, floored at zero.
    res.fan_compare     = (fan_nxt == 7'd0) ? 7'd0 : fan_nxt - 7'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ictrl_r <= 7'd0;
      red_r   <= 7'd0;
      green_r <= 7'd0;
      blue_r  <= 7'd0;
      fan_r   <= scp_pkg::FAN_RESET;
      chg_r   <= 1'b0;
    end else if (fire) begin
      ictrl_r <= ictrl_nxt;
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
      fan_r   <= fan_nxt;
      chg_r   <= chg_nxt;
    end
  end

endmodule

[rtl/settings_command_parser.sv]
// Settings command parser: reads a character stream of NAME:value; commands and
// keeps the charge current, light, fan and charge enable settings.
// Input channel (in_*): one character per request in in_tdata; in_tlast marks
// the last character of a received buffer.
// Result channel (out_*): one request per completed command; out_tuser holds
// the command code, out_tdata the value, status flags and all stored levels.
// A request that ends a command is processed from the input register, and its
// result is written to the result register and offered from there; a request
// that only advances the parser leaves nothing. Throughput is one character per
// cycle while no completing character waits on a held result: an input
// register holds the byte, single-pass logic updates the parser and settings,
// and a result register holds the outcome.
// When the receiver stalls with a result pending, characters that only advance
// the parser keep flowing; a character that would complete another command
// waits in the input register and in_tready drops until the result is taken.
// Reset (rst_n low at a clock edge) returns the parser to skipping blanks,
// clears both registers and sets all levels to zero, except the fan at 49.
`timescale 1ns / 1ps
`include "settings_command_parser_defines.svh"

module settings_command_parser #(
  parameter int FIELD_LIMIT = scp_pkg::FIELD_LIMIT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [10:0] parsed_value, [11] accepted, [12] save_request,
                                  // [19:13] current_level, [26:20] red_level,
                                  // [33:27] green_level_out, [40:34] blue_level_out,
                                  // [47:41] fan_percent, [48] charge_enable,
                                  // [55:49] fan_compare
  output logic [2:0]  out_tuser   // [2:0] command
);

  localparam int POS_W = $clog2(FIELD_LIMIT + 1);

  // Input register.
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;

  // Parser state.
  logic [1:0]       phase_r, phase_nxt;
  logic [6:0]       cand_r, cand_nxt;
  logic [POS_W-1:0] npos_r, npos_nxt;
  logic [POS_W-1:0] dpos_r, dpos_nxt;
  scp_pkg::num_t    num_r, num_nxt;

  // Result register.
  logic          out_valid_r;
  scp_pkg::res_t out_item_r;

  // Parser update before the end-of-buffer restart.
  logic [1:0]       upd_phase;
  logic [6:0]       upd_cand;
  logic [POS_W-1:0] upd_npos;
  logic [POS_W-1:0] upd_dpos;
  scp_pkg::num_t    upd_num;

  logic             is_blank;
  logic             in_name;
  logic [6:0]       base_cand;
  logic [POS_W-1:0] base_pos;
  logic [6:0]       feed_cand;
  logic [POS_W-1:0] feed_pos;
  logic [6:0]       end_cand;
  scp_pkg::num_t    val_num;
  logic [POS_W-1:0] val_dpos;
  logic             done;
  logic             out_free;
  logic             s1_go;
  logic             fire;
  scp_pkg::res_t    res;

  // A name starts at the first byte that is neither space nor tab.
  assign is_blank  = (s1_byte_r == scp_pkg::CHAR_SPACE) || (s1_byte_r == scp_pkg::CHAR_TAB);
  assign in_name   = (phase_r == scp_pkg::PH_NAME) || (phase_r == scp_pkg::PH_BLANK && !is_blank);
  assign base_cand = (phase_r == scp_pkg::PH_NAME) ? cand_r : scp_pkg::ALL_NAMES;
  assign base_pos  = (phase_r == scp_pkg::PH_NAME) ? npos_r : '0;

  scp_name_match #(
    .FIELD_LIMIT (FIELD_LIMIT),
    .POS_W       (POS_W)
  ) u_name (
    .data_byte (s1_byte_r),
    .cand_in   (base_cand),
    .pos_in    (base_pos),
    .feed_cand (feed_cand),
    .feed_pos  (feed_pos),
    .end_cand  (end_cand)
  );

  scp_value_reader #(
    .FIELD_LIMIT (FIELD_LIMIT),
    .POS_W       (POS_W)
  ) u_value (
    .data_byte (s1_byte_r),
    .num_in    (num_r),
    .dpos_in   (dpos_r),
    .num_out   (val_num),
    .dpos_out  (val_dpos)
  );

  always_comb begin
    upd_phase = phase_r;
    upd_cand  = cand_r;
    upd_npos  = npos_r;
    upd_dpos  = dpos_r;
    upd_num   = num_r;
    done      = 1'b0;
    if (phase_r == scp_pkg::PH_VALUE) begin
      // The semicolon closes the value and is not read as part of it.
      if (s1_byte_r == scp_pkg::CHAR_SEMI) begin
        done = 1'b1;
      end else begin
        upd_num  = val_num;
        upd_dpos = val_dpos;
      end
      if (s1_last_r) done = 1'b1;
    end else if (in_name) begin
      if (s1_byte_r == scp_pkg::CHAR_COLON) begin
        upd_phase = scp_pkg::PH_VALUE;
        upd_cand  = end_cand;
        upd_npos  = base_pos;
        upd_dpos  = '0;
        upd_num   = '{nphase: scp_pkg::NP_START, neg: 1'b0, mag: 10'd0};
        done      = s1_last_r;
      end else begin
        upd_phase = scp_pkg::PH_NAME;
        upd_cand  = feed_cand;
        upd_npos  = feed_pos;
      end
    end
  end

  // A completed command or the end of the buffer starts the parser afresh.
  always_comb begin
    if (done || s1_last_r) begin
      phase_nxt = scp_pkg::PH_BLANK;
      cand_nxt  = scp_pkg::ALL_NAMES;
      npos_nxt  = '0;
      dpos_nxt  = '0;
      num_nxt   = '{nphase: scp_pkg::NP_START, neg: 1'b0, mag: 10'd0};
    end else begin
      phase_nxt = upd_phase;
      cand_nxt  = upd_cand;
      npos_nxt  = upd_npos;
      dpos_nxt  = upd_dpos;
      num_nxt   = upd_num;
    end
  end

  // Only a byte that produces a result has to wait for the result register.
  // Nothing is taken while reset is held.
  assign out_free  = !out_valid_r || out_tready;
  assign s1_go     = s1_valid_r && (!done || out_free);
  assign fire      = s1_go && done;
  assign in_tready = rst_n && (!s1_valid_r || s1_go);

  scp_store u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .cand  (upd_cand),
    .num   (upd_num),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= scp_pkg::PH_BLANK;
      cand_r  <= scp_pkg::ALL_NAMES;
      npos_r  <= '0;
      dpos_r  <= '0;
      num_r   <= '{nphase: scp_pkg::NP_START, neg: 1'b0, mag: 10'd0};
    end else if (s1_go) begin
      phase_r <= phase_nxt;
      cand_r  <= cand_nxt;
      npos_r  <= npos_nxt;
      dpos_r  <= dpos_nxt;
      num_r   <= num_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_item_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_item_r.command;
  assign out_tdata  = {out_item_r.fan_compare,
                       out_item_r.charge_enable,
                       out_item_r.fan_percent,
                       out_item_r.blue_level_out,
                       out_item_r.green_level_out,
                       out_item_r.red_level,
                       out_item_r.current_level,
                       out_item_r.save_request,
                       out_item_r.accepted,
                       out_item_r.parsed_value};

  // A byte that completes a command cannot pass a result that is still held.
  `SCP_ASSERT_IMP(a_stall_on_full, s1_valid_r && done && out_valid_r && !out_tready, !in_tready, "completing byte passed a held result")

  // The end of a buffer always leaves the parser at the start of a new name.
  `SCP_ASSERT_NXT(a_restart_on_last, s1_go && s1_last_r, phase_r == scp_pkg::PH_BLANK && num_r.mag == 10'd0, "parser not restarted after buffer end")

  // A save request only comes from an accepted SAVE command.
  `SCP_ASSERT_IMP(a_save_is_save, out_valid_r && out_item_r.save_request, out_item_r.accepted && out_item_r.command == scp_pkg::CMD_SAVE, "save request without accepted SAVE")

  // Stored percentages never leave their range.
  `SCP_ASSERT_IMP(a_levels_in_range, out_valid_r, out_item_r.fan_percent <= scp_pkg::PCT_MAX && out_item_r.current_level <= scp_pkg::PCT_MAX, "stored level above 100")

endmodule
